@@ rtl/css_pkg.sv @@
package css_pkg;

	localparam int MAX_SIZE   = 128;
	localparam int PIXEL_BITS = 8;
	localparam int SIZE_BITS  = 8;
	localparam int POS_BITS   = $clog2(MAX_SIZE);
	localparam int SUM_BITS   = 11;
	localparam int MIN_SIZE   = 3;

	// result queue behind the stencil stage
	localparam int QUEUE_DEPTH = 3;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 2;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic                  first_of_frame;
	} px_word_t;

	typedef struct packed {
		logic [SUM_BITS-1:0] cross_sum;
		logic [POS_BITS-1:0] centre_row;
		logic [POS_BITS-1:0] centre_col;
	} res_word_t;

endpackage

@@ rtl/css_ram.sv @@
module css_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents when the same entry is written
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/cross_stencil_sum_unit.sv @@
// Five-point cross sum over a square image streamed in raster order, one pixel word per
// clock sustained; px_ready drops only when the three-entry result queue has no room for
// the sums in flight. For each interior pixel a result word (sum of the pixel and its four
// direct neighbours, with its row and column) is registered in stage 1 once the pixel
// below it is taken, then written to the result queue and offered from there; border
// positions give nothing. Two line stores hold the previous two rows: one 16-bit RAM read
// at the current column and one 8-bit copy read one column ahead, both rewritten in the
// cycle after the read, with forwarding when the next pixel hits the same entry. The line
// stores are not cleared: results need two full rows of the frame first. image_size is
// clamped to 3..128; the user must write it only while the block is idle, unchecked.
module cross_stencil_sum_unit
	import css_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [SIZE_BITS-1:0] cfg_data,
	input  logic                 px_valid,
	output logic                 px_ready,
	input  px_word_t             px,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_word_t            res
);

	logic [SIZE_BITS-1:0]  size_q;
	logic [POS_BITS-1:0]   row_q, col_q;
	logic [PIXEL_BITS-1:0] left_q;

	logic                  acc;
	logic [POS_BITS-1:0]   r0, c0, c0_ahead;
	logic                  col_last, row_last, res0;

	logic                  valid_s1, res_s1, hit_c_s1, hit_r_s1;
	logic [PIXEL_BITS-1:0] pix_s1, fwd_pix_s1, fwd_up_s1;
	logic [POS_BITS-1:0]   col_s1, row_s1;

	logic [2*PIXEL_BITS-1:0] pair_rd;
	logic [PIXEL_BITS-1:0]   ahead_rd;
	logic [PIXEL_BITS-1:0]   centre_eff, up_eff, right_eff;
	logic [SUM_BITS-1:0]     sum_s1;

	res_word_t            queue_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 push, pop;

	assign cfg_ready = 1'b1;

	// position of the incoming pixel
	always_comb begin
		r0 = px.first_of_frame ? '0 : row_q;
		c0 = px.first_of_frame ? '0 : col_q;
		if ({1'b0, c0} >= size_q) begin
			c0 = '0;
		end
		if ({1'b0, r0} >= size_q) begin
			r0 = '0;
		end
		col_last = ({1'b0, c0} + SIZE_BITS'(1)) >= size_q;
		row_last = ({1'b0, r0} + SIZE_BITS'(1)) >= size_q;
		res0     = (r0 >= POS_BITS'(2)) && (c0 >= POS_BITS'(1))
			&& (({1'b0, c0} + SIZE_BITS'(2)) <= size_q);
	end

	assign c0_ahead = c0 + POS_BITS'(1);
	assign acc      = px_valid && px_ready;

	// room for every result already in flight
	assign px_ready = ({1'b0, cnt_q} + {{QCNT_BITS{1'b0}}, res_s1})
		<= (QCNT_BITS+1)'(QUEUE_DEPTH - 1);

	// pair store: row above in the upper byte, row two above in the lower byte
	css_ram #(.WIDTH(2*PIXEL_BITS), .DEPTH(MAX_SIZE)) u_pair_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata ({pix_s1, centre_eff}),
		.raddr (c0),
		.rdata (pair_rd)
	);

	// copy of the row above, read one column ahead for the right neighbour
	css_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_SIZE)) u_ahead_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (pix_s1),
		.raddr (c0_ahead),
		.rdata (ahead_rd)
	);

	assign centre_eff = hit_c_s1 ? fwd_pix_s1 : pair_rd[2*PIXEL_BITS-1:PIXEL_BITS];
	assign up_eff     = hit_c_s1 ? fwd_up_s1 : pair_rd[PIXEL_BITS-1:0];
	assign right_eff  = hit_r_s1 ? fwd_pix_s1 : ahead_rd;

	assign sum_s1 = SUM_BITS'(left_q) + SUM_BITS'(centre_eff) + SUM_BITS'(right_eff)
		+ SUM_BITS'(up_eff) + SUM_BITS'(pix_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SIZE_BITS'(MAX_SIZE);
			row_q    <= '0;
			col_q    <= '0;
			left_q   <= '0;
			valid_s1 <= 1'b0;
			res_s1   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_data < SIZE_BITS'(MIN_SIZE)) begin
					size_q <= SIZE_BITS'(MIN_SIZE);
				end else if (cfg_data > SIZE_BITS'(MAX_SIZE)) begin
					size_q <= SIZE_BITS'(MAX_SIZE);
				end else begin
					size_q <= cfg_data;
				end
			end
			if (acc) begin
				col_q <= col_last ? '0 : c0 + POS_BITS'(1);
				if (col_last) begin
					row_q <= row_last ? '0 : r0 + POS_BITS'(1);
				end else begin
					row_q <= r0;
				end
			end
			if (valid_s1) begin
				left_q <= centre_eff;
			end
			valid_s1 <= acc;
			res_s1   <= acc && res0;
		end
	end

	// stage 1 payload, with forwarding of the write that lands on the read edge
	always_ff @(posedge clk) begin
		pix_s1     <= px.pixel;
		col_s1     <= c0;
		row_s1     <= r0 - POS_BITS'(1);
		hit_c_s1   <= valid_s1 && (col_s1 == c0);
		hit_r_s1   <= valid_s1 && (col_s1 == c0_ahead);
		fwd_pix_s1 <= pix_s1;
		fwd_up_s1  <= centre_eff;
	end

	assign push = res_s1;
	assign pop  = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{cross_sum: sum_s1, centre_row: row_s1, centre_col: col_s1};
		end
	end

	assign res_valid = (cnt_q != '0);
	assign res       = queue_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && (cnt_q == QCNT_BITS'(QUEUE_DEPTH))))
		else $error("result queue overflow");

	a_s1_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(px_valid && px_ready))
		else $error("stage 1 without an accepted word");

	a_res_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		res_s1 |-> valid_s1)
		else $error("result flag without stage 1 word");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.centre_row != '0) && (res.centre_col != '0))
		else $error("border position reported");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(px_valid && px_ready) |=> ({1'b0, col_q} < size_q) && ({1'b0, row_q} < size_q))
		else $error("position counter beyond image size");

endmodule

@@ tb/tb.sv @@
module tb
	import css_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PIXEL_BITS-1:0] PATTERN [9] = '{
		8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'h00
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [SIZE_BITS-1:0] cfg_data = '0;
	logic                 px_valid = 1'b0;
	logic                 px_ready;
	px_word_t             px = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	res_word_t            res;

	px_word_t  pixels_pending [$];
	res_word_t cross_sums_due [$];
	res_word_t next_sum;
	res_word_t due_sum;
	int        px_queued = 0;
	int        px_accepted = 0;
	int        failures = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;

	// mirror of the stencil state
	int unsigned           frame_side = MAX_SIZE;
	logic [PIXEL_BITS-1:0] line_above [MAX_SIZE];
	logic [PIXEL_BITS-1:0] line_two_above [MAX_SIZE];
	logic [PIXEL_BITS-1:0] left_tap = '0;
	int unsigned           cur_row = 0;
	int unsigned           cur_col = 0;

	cross_stencil_sum_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.px_valid (px_valid),
		.px_ready (px_ready),
		.px       (px),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always #2 clk = ~clk;

	// place one pixel word and tell whether its centre above gives a sum
	function automatic bit cross_stencil_step(input px_word_t w, output res_word_t r);
		int unsigned           n;
		int unsigned           ri;
		int unsigned           ci;
		logic [PIXEL_BITS-1:0] centre;
		logic [PIXEL_BITS-1:0] right_px;
		logic [PIXEL_BITS-1:0] up_px;
		logic [SUM_BITS-1:0]   total;
		bit                    hit;
		n = frame_side;
		hit = 1'b0;
		r = '0;
		if (w.first_of_frame) begin
			cur_row = 0;
			cur_col = 0;
		end
		if (cur_col >= n) begin
			cur_col = 0;
		end
		if (cur_row >= n) begin
			cur_row = 0;
		end
		ri = cur_row;
		ci = cur_col;
		centre = line_above[ci];
		right_px = (ci + 1 < n) ? line_above[ci + 1] : '0;
		up_px = line_two_above[ci];
		if (ri >= 2 && ci >= 1 && ci + 2 <= n) begin
			total = left_tap;
			total = total + centre + right_px + up_px + w.pixel;
			r.cross_sum = total;
			r.centre_row = POS_BITS'(ri - 1);
			r.centre_col = POS_BITS'(ci);
			hit = 1'b1;
		end
		line_two_above[ci] = centre;
		line_above[ci] = w.pixel;
		left_tap = centre;
		if (ci + 1 >= n) begin
			cur_col = 0;
			cur_row = (ri + 1 >= n) ? 0 : ri + 1;
		end else begin
			cur_col = ci + 1;
		end
		return hit;
	endfunction

	always @(posedge clk) begin
		if (px_valid && px_ready) begin
			if (cross_stencil_step(px, next_sum)) begin
				cross_sums_due.push_back(next_sum);
			end
			px_accepted++;
		end
		if (!arst_n) begin
			px_valid <= 1'b0;
		end else if (!px_valid || px_ready) begin
			if (pixels_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				px <= pixels_pending.pop_front();
				px_valid <= 1'b1;
			end else begin
				px_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (cross_sums_due.size() == 0) begin
				$error("result word with none due: sum %0d row %0d col %0d",
					res.cross_sum, res.centre_row, res.centre_col);
				failures++;
			end else begin
				due_sum = cross_sums_due.pop_front();
				if (res.cross_sum !== due_sum.cross_sum) begin
					$error("cross_sum expected %0d got %0d", due_sum.cross_sum, res.cross_sum);
					failures++;
				end
				if (res.centre_row !== due_sum.centre_row) begin
					$error("centre_row expected %0d got %0d", due_sum.centre_row,
						res.centre_row);
					failures++;
				end
				if (res.centre_col !== due_sum.centre_col) begin
					$error("centre_col expected %0d got %0d", due_sum.centre_col,
						res.centre_col);
					failures++;
				end
			end
		end
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [PIXEL_BITS-1:0] any_pixel();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return '1;
		end
		return PIXEL_BITS'($urandom_range(255));
	endfunction

	task automatic queue_pixel(input logic [PIXEL_BITS-1:0] p, input bit sof);
		px_word_t w;
		w.pixel = p;
		w.first_of_frame = sof;
		pixels_pending.push_back(w);
		px_queued++;
	endtask

	// all words taken and all sums back, then a wait for border pixels still in flight
	task automatic wait_idle();
		int spins;
		spins = 0;
		@(negedge clk);
		while ((px_accepted != px_queued || cross_sums_due.size() != 0) && spins < 100000) begin
			@(negedge clk);
			spins++;
		end
		if (spins >= 100000) begin
			$error("%0d result words still due", cross_sums_due.size());
			failures++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_side(input logic [SIZE_BITS-1:0] raw);
		wait_idle();
		@(posedge clk);
		cfg_data <= raw;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (raw < MIN_SIZE) begin
			frame_side = MIN_SIZE;
		end else if (raw > MAX_SIZE) begin
			frame_side = MAX_SIZE;
		end else begin
			frame_side = raw;
		end
	endtask

	// frames of random content; a larger side always restarts the frame so that
	// no line store entry is read before it was written
	task automatic random_segment(input logic [SIZE_BITS-1:0] raw, input int items,
		input int noise_pct);
		int unsigned old_side;
		int          area;
		int          pos;
		bit          sof;
		old_side = frame_side;
		write_side(raw);
		area = frame_side * frame_side;
		pos = 0;
		for (int i = 0; i < items; i++) begin
			sof = 1'b0;
			if (i == 0) begin
				sof = (frame_side > old_side) || ($urandom_range(1) == 1);
			end else if (pos == 0) begin
				sof = ($urandom_range(99) < 80);
			end else if ($urandom_range(99) < noise_pct) begin
				sof = 1'b1;
				pos = 0;
			end
			queue_pixel(any_pixel(), sof);
			pos = (pos + 1) % area;
		end
	endtask

	initial begin
		send_idle_pct = 16;
		recv_idle_pct = 82;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// smallest frame: all ones, then a pattern frame reached by wrap,
		// two stray words, and a restart of zeros
		write_side(8'd0);
		for (int i = 0; i < 9; i++) begin
			queue_pixel('1, i == 0);
		end
		for (int i = 0; i < 9; i++) begin
			queue_pixel(PATTERN[i], 1'b0);
		end
		queue_pixel(8'h3C, 1'b0);
		queue_pixel(8'hC3, 1'b0);
		for (int i = 0; i < 8; i++) begin
			queue_pixel('0, i == 0);
		end

		random_segment(8'd2, 60, 3);
		random_segment(SIZE_BITS'($urandom_range(9, 4)), 100, 3);
		random_segment(SIZE_BITS'($urandom_range(16, 3)), 100, 3);
		random_segment(8'd1, 40, 3);
		wait_idle();

		send_idle_pct = 82;
		recv_idle_pct = 16;
		random_segment(8'd255, 40, 0);
		random_segment(SIZE_BITS'($urandom_range(40, 5)), 100, 3);
		random_segment(8'd3, 50, 3);
		random_segment(SIZE_BITS'($urandom_range(12, 3)), 100, 3);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// two full rows and part of the third at the largest side, then a
		// smaller side that may pick up in the middle of that frame
		random_segment(8'd129, 280, 0);
		random_segment(SIZE_BITS'($urandom_range(10, 3)), 40, 3);
		wait_idle();

		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/css_pkg.sv
rtl/css_ram.sv
rtl/cross_stencil_sum_unit.sv
tb/tb.sv
